@@ design/tmpg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tmpg_pkg
// Shared constants, palette, codes and stage types of the text-mode pixel
// generator.
// ----------------------------------------------------------------------------
package tmpg_pkg;

   localparam int GLYPH_HEIGHT = 16;
   localparam int GLYPH_WIDTH  = 8;
   localparam int GLYPH_COUNT  = 256;

   localparam int STORE_DEPTH  = GLYPH_COUNT * GLYPH_HEIGHT;
   localparam int ADDR_W       = $clog2(STORE_DEPTH);
   localparam int COUNT_W      = $clog2(GLYPH_WIDTH);

   localparam int OP_W         = 2;
   localparam int CODE_W       = 8;
   localparam int ATTR_W       = 8;
   localparam int COL_W        = 7;
   localparam int ROW_W        = 5;
   localparam int LINE_W       = 4;
   localparam int BYTE_W       = 8;
   localparam int X_W          = 10;
   localparam int Y_W          = 9;
   localparam int CHAN_W       = 8;
   localparam int COLOR_W      = 3 * CHAN_W;
   localparam int BLINK_W      = 6;

   localparam int CSR_INDEX_W  = 4;
   localparam int CSR_DATA_W   = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_CURSOR_COLUMN = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_CURSOR_ROW    = CSR_INDEX_W'(1);

   localparam logic [BLINK_W-1:0] BLINK_WRAP        = BLINK_W'(60);
   localparam logic [BLINK_W-1:0] BLINK_SHOW        = BLINK_W'(30);
   localparam logic [LINE_W-1:0]  CURSOR_FIRST_LINE = LINE_W'(12);

   localparam logic [CODE_W-1:0]  CODE_MASK  = CODE_W'(GLYPH_COUNT - 1);
   localparam logic [LINE_W-1:0]  LINE_MASK  = LINE_W'(GLYPH_HEIGHT - 1);
   localparam logic [COUNT_W-1:0] LAST_PIXEL = COUNT_W'(GLYPH_WIDTH - 1);

   typedef enum logic [OP_W-1:0] {
      OP_WRITE_FONT = 2'd0,
      OP_RENDER     = 2'd1,
      OP_FRAME_TICK = 2'd2
   } op_type;

   localparam logic [COLOR_W-1:0] PALETTE [16] = '{
      24'h000000, 24'h0000aa, 24'h00aa00, 24'h00aaaa,
      24'haa0000, 24'haa00aa, 24'haa5500, 24'haaaaaa,
      24'h555555, 24'h5555ff, 24'h55ff55, 24'h55ffff,
      24'hff5555, 24'hff55ff, 24'hffff55, 24'hffffff
   };

   // after glyph fetch
   typedef struct packed {
      logic [BYTE_W-1:0] glyph_bits;
      logic [ATTR_W-1:0] attribute;
      logic [COL_W-1:0]  cell_column;
      logic [ROW_W-1:0]  cell_row;
      logic [LINE_W-1:0] line;
      logic              cursor_hit;
   } fetch_type;

   // after color lookup
   typedef struct packed {
      logic [BYTE_W-1:0]  glyph_bits;
      logic [COLOR_W-1:0] fg;
      logic [COLOR_W-1:0] bg;
      logic [X_W-1:0]     base_x;
      logic [Y_W-1:0]     pixel_y;
   } color_type;

endpackage
`default_nettype wire

@@ design/tmpg_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tmpg interfaces
// Request, response and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tmpg_req_if;
   import tmpg_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [CODE_W-1:0] character_code;
   logic [ATTR_W-1:0] attribute;
   logic [COL_W-1:0]  cell_column;
   logic [ROW_W-1:0]  cell_row;
   logic [LINE_W-1:0] glyph_line;
   logic [BYTE_W-1:0] font_byte;

   modport source (
      output valid, op, character_code, attribute, cell_column, cell_row,
             glyph_line, font_byte,
      input  ready
   );
   modport sink (
      input  valid, op, character_code, attribute, cell_column, cell_row,
             glyph_line, font_byte,
      output ready
   );
endinterface

interface tmpg_rsp_if;
   import tmpg_pkg::*;

   logic              valid;
   logic              ready;
   logic [X_W-1:0]    pixel_x;
   logic [Y_W-1:0]    pixel_y;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;
   logic              last;

   modport source (
      output valid, pixel_x, pixel_y, red, green, blue, last,
      input  ready
   );
   modport sink (
      input  valid, pixel_x, pixel_y, red, green, blue, last,
      output ready
   );
endinterface

interface tmpg_csr_if;
   import tmpg_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ design/tmpg_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tmpg_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tmpg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] write_address,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic                     read_enable,
   input  wire logic [$clog2(DEPTH)-1:0] read_address,
   output logic      [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_address] <= write_data;
      end
      if (read_enable) begin
         read_data <= mem[read_address];
      end
   end

endmodule
`default_nettype wire

@@ design/tmpg_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tmpg_front
// Request intake: font writes, blink counter, cursor registers and the
// glyph fetch stage.
// ----------------------------------------------------------------------------
module tmpg_front (
   input  wire logic          clock,
   input  wire logic          reset,
   tmpg_req_if.sink           req_ch,
   tmpg_csr_if.sink           csr_ch,
   output logic               fetch_valid,
   output tmpg_pkg::fetch_type fetch_data,
   input  wire logic          fetch_ready
);
   import tmpg_pkg::*;

   logic               s1_valid_ff, s1_valid_in;
   logic [ATTR_W-1:0]  attr_ff;
   logic [COL_W-1:0]   col_ff;
   logic [ROW_W-1:0]   row_ff;
   logic [LINE_W-1:0]  line_ff;
   logic               hit_ff;
   logic [BLINK_W-1:0] blink_ff, blink_in;
   logic [COL_W-1:0]   cursor_col_ff, cursor_col_in;
   logic [ROW_W-1:0]   cursor_row_ff, cursor_row_in;

   logic               accept;
   logic               render;
   logic               font_write;
   logic               tick;
   logic [LINE_W-1:0]  line;
   logic [CODE_W-1:0]  code;
   logic [ADDR_W-1:0]  address;
   logic               hit;
   logic [BYTE_W-1:0]  glyph_bits;

   assign req_ch.ready = !s1_valid_ff || fetch_ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign render       = accept && (req_ch.op == OP_RENDER);
   assign font_write   = accept && (req_ch.op == OP_WRITE_FONT);
   assign tick         = accept && (req_ch.op == OP_FRAME_TICK);

   assign line    = req_ch.glyph_line & LINE_MASK;
   assign code    = req_ch.character_code & CODE_MASK;
   assign address = ADDR_W'(code) * ADDR_W'(GLYPH_HEIGHT) + ADDR_W'(line);

   assign hit = (req_ch.cell_column == cursor_col_ff) && (req_ch.cell_row == cursor_row_ff)
                && (blink_ff > BLINK_SHOW) && (line > CURSOR_FIRST_LINE);

   tmpg_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_DEPTH)
   ) u_glyph_store (
      .clock         (clock),
      .write_enable  (font_write),
      .write_address (address),
      .write_data    (req_ch.font_byte),
      .read_enable   (render),
      .read_address  (address),
      .read_data     (glyph_bits)
   );

   // register writes
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_CURSOR_COLUMN: cursor_col_in = csr_ch.data[COL_W-1:0];
            CSR_CURSOR_ROW:    cursor_row_in = csr_ch.data[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      blink_in = blink_ff;
      if (tick) begin
         blink_in = (blink_ff < BLINK_WRAP) ? blink_ff + BLINK_W'(1) : '0;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_ch.ready) begin
         s1_valid_in = render;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         blink_ff      <= '0;
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         blink_ff      <= blink_in;
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (render) begin
         attr_ff <= req_ch.attribute;
         col_ff  <= req_ch.cell_column;
         row_ff  <= req_ch.cell_row;
         line_ff <= line;
         hit_ff  <= hit;
      end
   end

   assign fetch_valid = s1_valid_ff;
   assign fetch_data  = '{glyph_bits:  glyph_bits,
                          attribute:   attr_ff,
                          cell_column: col_ff,
                          cell_row:    row_ff,
                          line:        line_ff,
                          cursor_hit:  hit_ff};

`ifndef ASSERT_OFF
   a_blink_range: assert property (@(posedge clock) disable iff (reset)
      blink_ff <= BLINK_WRAP)
      else $error("blink counter beyond wrap value");

   a_fetch_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !fetch_ready) |=> (s1_valid_ff && $stable(fetch_data)))
      else $error("fetch stage changed while stalled");
`endif

endmodule
`default_nettype wire

@@ design/tmpg_color.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tmpg_color
// Palette lookup, cursor override and screen coordinate stage.
// ----------------------------------------------------------------------------
module tmpg_color (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           fetch_valid,
   input  tmpg_pkg::fetch_type fetch_data,
   output logic                fetch_ready,
   output logic                color_valid,
   output tmpg_pkg::color_type color_data,
   input  wire logic           color_ready
);
   import tmpg_pkg::*;

   logic      s2_valid_ff, s2_valid_in;
   color_type s2_ff, s2_in;

   assign fetch_ready = !s2_valid_ff || color_ready;

   always_comb begin
      s2_in.glyph_bits = fetch_data.glyph_bits;
      s2_in.fg         = PALETTE[fetch_data.attribute[3:0]];
      s2_in.bg         = fetch_data.cursor_hit ? PALETTE[fetch_data.attribute[3:0]]
                                               : PALETTE[fetch_data.attribute[7:4]];
      s2_in.base_x     = X_W'(fetch_data.cell_column) * X_W'(GLYPH_WIDTH);
      s2_in.pixel_y    = Y_W'(fetch_data.cell_row) * Y_W'(GLYPH_HEIGHT)
                         + Y_W'(fetch_data.line);
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (fetch_ready) begin
         s2_valid_in = fetch_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fetch_valid && fetch_ready) begin
         s2_ff <= s2_in;
      end
   end

   assign color_valid = s2_valid_ff;
   assign color_data  = s2_ff;

endmodule
`default_nettype wire

@@ design/tmpg_serializer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tmpg_serializer
// Output stage: shifts the glyph byte out one pixel per response.
// ----------------------------------------------------------------------------
module tmpg_serializer (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           color_valid,
   input  tmpg_pkg::color_type color_data,
   output logic                color_ready,
   tmpg_rsp_if.source          rsp_ch
);
   import tmpg_pkg::*;

   logic               s3_valid_ff, s3_valid_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [BYTE_W-1:0]  bits_ff, bits_in;
   logic [X_W-1:0]     x_ff, x_in;
   logic [COLOR_W-1:0] fg_ff;
   logic [COLOR_W-1:0] bg_ff;
   logic [Y_W-1:0]     y_ff;

   logic               emit;
   logic               done;
   logic               load;
   logic [COLOR_W-1:0] color;

   assign emit        = s3_valid_ff && rsp_ch.ready;
   assign done        = emit && (count_ff == LAST_PIXEL);
   assign color_ready = !s3_valid_ff || done;
   assign load        = color_valid && color_ready;

   always_comb begin
      s3_valid_in = s3_valid_ff;
      count_in    = count_ff;
      bits_in     = bits_ff;
      x_in        = x_ff;
      if (load) begin
         s3_valid_in = 1'b1;
         count_in    = '0;
         bits_in     = color_data.glyph_bits;
         x_in        = color_data.base_x;
      end else if (emit) begin
         s3_valid_in = !done;
         count_in    = count_ff + COUNT_W'(1);
         bits_in     = {bits_ff[BYTE_W-2:0], 1'b0};
         x_in        = x_ff + X_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         count_ff    <= '0;
      end else begin
         s3_valid_ff <= s3_valid_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff <= bits_in;
      x_ff    <= x_in;
      if (load) begin
         fg_ff <= color_data.fg;
         bg_ff <= color_data.bg;
         y_ff  <= color_data.pixel_y;
      end
   end

   assign color = bits_ff[BYTE_W-1] ? fg_ff : bg_ff;

   assign rsp_ch.valid   = s3_valid_ff;
   assign rsp_ch.pixel_x = x_ff;
   assign rsp_ch.pixel_y = y_ff;
   assign rsp_ch.red     = color[3*CHAN_W-1:2*CHAN_W];
   assign rsp_ch.green   = color[2*CHAN_W-1:CHAN_W];
   assign rsp_ch.blue    = color[CHAN_W-1:0];
   assign rsp_ch.last    = (count_ff == LAST_PIXEL);

`ifndef ASSERT_OFF
   a_x_tracks_count: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (x_ff[COUNT_W-1:0] == count_ff))
      else $error("pixel x out of step with pixel count");
`endif

endmodule
`default_nettype wire

@@ design/text_mode_pixel_generator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// text_mode_pixel_generator
// Text-mode character generator: 8x16 glyphs, 16-color palette, blinking
// cursor.
// ----------------------------------------------------------------------------
// A render request yields eight pixel responses, one per cycle while the
// sink is ready, shifted out by the output serializer; font writes and frame
// ticks are taken one per cycle while the request channel is ready. The first
// pixel of a render passes the glyph store read, the palette stage and the
// serializer in turn. Up to two further renders are buffered behind the
// pixel being shown. The glyph store holds garbage until written.
module text_mode_pixel_generator (
   input  wire logic clock,
   input  wire logic reset,
   tmpg_req_if.sink   req_ch,
   tmpg_csr_if.sink   csr_ch,
   tmpg_rsp_if.source rsp_ch
);
   import tmpg_pkg::*;

   logic      fetch_valid;
   fetch_type fetch_data;
   logic      fetch_ready;
   logic      color_valid;
   color_type color_data;
   logic      color_ready;

   tmpg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .csr_ch      (csr_ch),
      .fetch_valid (fetch_valid),
      .fetch_data  (fetch_data),
      .fetch_ready (fetch_ready)
   );

   tmpg_color u_color (
      .clock       (clock),
      .reset       (reset),
      .fetch_valid (fetch_valid),
      .fetch_data  (fetch_data),
      .fetch_ready (fetch_ready),
      .color_valid (color_valid),
      .color_data  (color_data),
      .color_ready (color_ready)
   );

   tmpg_serializer u_serializer (
      .clock       (clock),
      .reset       (reset),
      .color_valid (color_valid),
      .color_data  (color_data),
      .color_ready (color_ready),
      .rsp_ch      (rsp_ch)
   );

endmodule
`default_nettype wire

@@ sim/text_mode_pixel_generator_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_mode_pixel_generator_test
// Self-checking bench for the text-mode pixel generator. A queue-fed driver
// offers font writes, cell renders, frame ticks and unused op codes; a
// monitor predicts every pixel of every accepted render from its own copy of
// the glyph store, blink counter and cursor registers and checks the pixel
// stream in order. Four phases vary the cursor and the idle/stall mix.
// ----------------------------------------------------------------------------
module text_mode_pixel_generator_test;
   import tmpg_pkg::*;

   localparam int CYCLE_LIMIT      = 200000;
   localparam int SETTLE_CYCLES    = 12;
   localparam int HOLD_CYCLES      = 300;
   localparam int RANDOM_PER_PHASE = 50;

   localparam logic [OP_W-1:0]    OP_UNUSED        = 2'd3;
   localparam logic [BLINK_W-1:0] TICK_WRAP        = 6'd60;
   localparam logic [BLINK_W-1:0] BLINK_ON_ABOVE   = 6'd30;
   localparam logic [LINE_W-1:0]  CURSOR_FROM_LINE = 4'd12;

   localparam logic [COLOR_W-1:0] SHADES [16] = '{
      24'h000000, 24'h0000aa, 24'h00aa00, 24'h00aaaa,
      24'haa0000, 24'haa00aa, 24'haa5500, 24'haaaaaa,
      24'h555555, 24'h5555ff, 24'h55ff55, 24'h55ffff,
      24'hff5555, 24'hff55ff, 24'hffff55, 24'hffffff
   };

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [CODE_W-1:0] code;
      logic [ATTR_W-1:0] attribute;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic [LINE_W-1:0] line;
      logic [BYTE_W-1:0] font_byte;
   } request_type;

   typedef struct packed {
      logic [X_W-1:0]    x;
      logic [Y_W-1:0]    y;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              last;
   } pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tmpg_req_if req_ch ();
   tmpg_rsp_if rsp_ch ();
   tmpg_csr_if csr_ch ();

   text_mode_pixel_generator uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .csr_ch (csr_ch),
      .rsp_ch (rsp_ch)
   );

   always #1 clock = ~clock;

   request_type request_backlog [$];
   pixel_type   pixels_due [$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_requests  = 0;
   int hold_served    = 0;
   int hold_left      = 0;
   logic req_fire = 1'b0;
   logic csr_fire = 1'b0;
   int errors = 0;
   int cycles = 0;

   // mirrored block state
   logic [BYTE_W-1:0]  font_copy [STORE_DEPTH];
   logic [BLINK_W-1:0] blink_copy      = '0;
   logic [COL_W-1:0]   cursor_col_copy = '0;
   logic [ROW_W-1:0]   cursor_row_copy = '0;

   int font_writes = 0, renders = 0, pixels_checked = 0, ticks = 0;
   int cursor_lines = 0, blink_wraps = 0, unused_ops = 0;

   // generation side: which glyph entries hold data
   bit                font_known [STORE_DEPTH];
   logic [ADDR_W-1:0] known_addrs [$];
   logic [COL_W-1:0]  gen_col = '0;
   logic [ROW_W-1:0]  gen_row = '0;

   task automatic apply_request(input request_type rq);
      logic [ADDR_W-1:0]  addr;
      logic [BYTE_W-1:0]  bits;
      logic [COLOR_W-1:0] fg;
      logic [COLOR_W-1:0] bg;
      logic [COLOR_W-1:0] shade;
      pixel_type          px;
      addr = {rq.code, rq.line};
      case (rq.op)
         OP_WRITE_FONT: begin
            font_copy[addr] = rq.font_byte;
            font_writes++;
         end
         OP_FRAME_TICK: begin
            ticks++;
            if (blink_copy < TICK_WRAP) begin
               blink_copy = blink_copy + 1'b1;
            end else begin
               blink_copy = '0;
               blink_wraps++;
            end
         end
         OP_RENDER: begin
            renders++;
            bits = font_copy[addr];
            fg = SHADES[rq.attribute[3:0]];
            bg = SHADES[rq.attribute[7:4]];
            if (rq.col == cursor_col_copy && rq.row == cursor_row_copy &&
                blink_copy > BLINK_ON_ABOVE && rq.line > CURSOR_FROM_LINE) begin
               bg = fg;
               cursor_lines++;
            end
            for (int k = 0; k < GLYPH_WIDTH; k++) begin
               shade    = bits[BYTE_W-1] ? fg : bg;
               px.x     = X_W'(int'(rq.col) * GLYPH_WIDTH + k);
               px.y     = Y_W'(int'(rq.row) * GLYPH_HEIGHT + int'(rq.line));
               px.red   = shade[23:16];
               px.green = shade[15:8];
               px.blue  = shade[7:0];
               px.last  = (k == GLYPH_WIDTH - 1);
               pixels_due.push_back(px);
               bits = bits << 1;
            end
         end
         default: unused_ops++;
      endcase
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: pixel %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   // monitor and predictor
   always @(posedge clock) begin
      pixel_type   want;
      request_type seen;
      if (reset) begin
         req_fire <= 1'b0;
         csr_fire <= 1'b0;
      end else begin
         req_fire <= req_ch.valid && req_ch.ready;
         csr_fire <= csr_ch.valid && csr_ch.ready;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pixels_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected pixel, expected none, got x=%0d y=%0d", $time,
                        rsp_ch.pixel_x, rsp_ch.pixel_y);
            end else begin
               want = pixels_due.pop_front();
               pixels_checked++;
               check_field("x", want.x, rsp_ch.pixel_x);
               check_field("y", want.y, rsp_ch.pixel_y);
               check_field("red", want.red, rsp_ch.red);
               check_field("green", want.green, rsp_ch.green);
               check_field("blue", want.blue, rsp_ch.blue);
               check_field("last", want.last, rsp_ch.last);
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_CURSOR_COLUMN: cursor_col_copy = COL_W'(csr_ch.data);
               CSR_CURSOR_ROW:    cursor_row_copy = ROW_W'(csr_ch.data);
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            seen.op        = req_ch.op;
            seen.code      = req_ch.character_code;
            seen.attribute = req_ch.attribute;
            seen.col       = req_ch.cell_column;
            seen.row       = req_ch.cell_row;
            seen.line      = req_ch.glyph_line;
            seen.font_byte = req_ch.font_byte;
            apply_request(seen);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // request driver
   always @(negedge clock) begin
      request_type rq;
      if (!reset && (!req_ch.valid || req_fire)) begin
         if (request_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            rq = request_backlog.pop_front();
            req_ch.valid          <= 1'b1;
            req_ch.op             <= rq.op;
            req_ch.character_code <= rq.code;
            req_ch.attribute      <= rq.attribute;
            req_ch.cell_column    <= rq.col;
            req_ch.cell_row       <= rq.row;
            req_ch.glyph_line     <= rq.line;
            req_ch.font_byte      <= rq.font_byte;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // pixel sink with random stalls and the long hold-off
   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   function automatic request_type noise_request(input logic [OP_W-1:0] op);
      request_type rq;
      rq.op        = op;
      rq.code      = CODE_W'($urandom);
      rq.attribute = ATTR_W'($urandom);
      rq.col       = COL_W'($urandom);
      rq.row       = ROW_W'($urandom);
      rq.line      = LINE_W'($urandom);
      rq.font_byte = BYTE_W'($urandom);
      return rq;
   endfunction

   task automatic push_write(input logic [CODE_W-1:0] code, input logic [LINE_W-1:0] line,
                             input logic [BYTE_W-1:0] value);
      request_type rq;
      rq = noise_request(OP_WRITE_FONT);
      rq.code      = code;
      rq.line      = line;
      rq.font_byte = value;
      if (!font_known[{code, line}]) begin
         font_known[{code, line}] = 1'b1;
         known_addrs.push_back({code, line});
      end
      request_backlog.push_back(rq);
   endtask

   task automatic push_render(input logic [CODE_W-1:0] code, input logic [LINE_W-1:0] line,
                              input logic [ATTR_W-1:0] attribute,
                              input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
      request_type rq;
      rq = noise_request(OP_RENDER);
      rq.code      = code;
      rq.line      = line;
      rq.attribute = attribute;
      rq.col       = col;
      rq.row       = row;
      request_backlog.push_back(rq);
   endtask

   task automatic pick_cell(output logic [COL_W-1:0] col, output logic [ROW_W-1:0] row);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         col = gen_col;
         row = gen_row;
      end else if (pick < 85) begin
         col = COL_W'($urandom_range(0, 79));
         row = ROW_W'($urandom_range(0, 24));
      end else begin
         col = COL_W'($urandom);
         row = ROW_W'($urandom);
      end
   endtask

   task automatic random_requests(input int count);
      int                pushed;
      int                pick;
      int                burst;
      logic [ADDR_W-1:0] addr;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      pushed = 0;
      while (pushed < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            push_write(CODE_W'($urandom), LINE_W'($urandom), BYTE_W'($urandom));
            pushed++;
         end else if (pick < 40) begin
            // fresh glyph line, drawn right after it is stored
            addr[ADDR_W-1:LINE_W] = CODE_W'($urandom);
            addr[LINE_W-1:0] = $urandom_range(0, 1) ? LINE_W'($urandom_range(13, 15))
                                                    : LINE_W'($urandom);
            push_write(addr[ADDR_W-1:LINE_W], addr[LINE_W-1:0], BYTE_W'($urandom));
            pick_cell(col, row);
            push_render(addr[ADDR_W-1:LINE_W], addr[LINE_W-1:0], ATTR_W'($urandom), col, row);
            pushed += 2;
         end else if (pick < 65) begin
            addr = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
            pick_cell(col, row);
            push_render(addr[ADDR_W-1:LINE_W], addr[LINE_W-1:0], ATTR_W'($urandom), col, row);
            pushed++;
         end else if (pick < 95) begin
            burst = $urandom_range(1, 4);
            repeat (burst) request_backlog.push_back(noise_request(OP_FRAME_TICK));
            pushed += burst;
         end else begin
            request_backlog.push_back(noise_request(OP_UNUSED));
            pushed++;
         end
      end
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= value;
      do @(negedge clock); while (!csr_fire);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (request_backlog.size() != 0 || req_ch.valid || pixels_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      req_ch.valid          = 1'b0;
      req_ch.op             = '0;
      req_ch.character_code = '0;
      req_ch.attribute      = '0;
      req_ch.cell_column    = '0;
      req_ch.cell_row       = '0;
      req_ch.glyph_line     = '0;
      req_ch.font_byte      = '0;
      csr_ch.valid          = 1'b0;
      csr_ch.index          = '0;
      csr_ch.data           = '0;
      rsp_ch.ready          = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, overwrite, unused op, cursor below blink
      push_write(8'h00, 4'd0, 8'h80);
      push_write(8'hff, 4'd15, 8'hff);
      push_write(8'h41, 4'd13, 8'h01);
      push_write(8'h41, 4'd12, 8'ha5);
      push_write(8'h7e, 4'd7, 8'h00);
      push_render(8'h00, 4'd0, 8'h0f, 7'd0, 5'd0);
      push_render(8'hff, 4'd15, 8'hf0, 7'd79, 5'd24);
      push_render(8'h41, 4'd13, 8'h1e, 7'd127, 5'd31);
      push_render(8'h41, 4'd12, 8'hff, 7'd0, 5'd0);
      push_render(8'h7e, 4'd7, 8'h00, 7'd40, 5'd12);
      push_render(8'h00, 4'd0, 8'h70, 7'd80, 5'd25);
      request_backlog.push_back(noise_request(OP_UNUSED));
      request_backlog.push_back(noise_request(OP_FRAME_TICK));
      request_backlog.push_back(noise_request(OP_FRAME_TICK));
      push_render(8'h41, 4'd13, 8'h4c, 7'd0, 5'd0);
      push_write(8'h00, 4'd0, 8'h3c);
      push_render(8'h00, 4'd0, 8'h8a, 7'd1, 5'd1);
      random_requests(RANDOM_PER_PHASE);
      wait_idle();

      // far corner of the grid, sender gaps
      write_register(CSR_CURSOR_COLUMN, 8'd79);
      write_register(CSR_CURSOR_ROW, 8'd24);
      gen_col = 7'd79;
      gen_row = 5'd24;
      send_idle_pct = 52;
      random_requests(RANDOM_PER_PHASE);
      wait_idle();

      // all ones, masked to the register widths, with sink stalls and a hold-off
      write_register(CSR_CURSOR_COLUMN, 8'hff);
      write_register(CSR_CURSOR_ROW, 8'hff);
      gen_col = 7'd127;
      gen_row = 5'd31;
      send_idle_pct  = 0;
      recv_stall_pct = 52;
      random_requests(RANDOM_PER_PHASE);
      @(posedge clock);
      hold_requests++;
      wait_idle();

      write_register(CSR_CURSOR_COLUMN, CSR_DATA_W'($urandom_range(0, 79)));
      write_register(CSR_CURSOR_ROW, CSR_DATA_W'($urandom_range(0, 24)));
      gen_col = cursor_col_copy;
      gen_row = cursor_row_copy;
      send_idle_pct  = 8;
      recv_stall_pct = 8;
      random_requests(RANDOM_PER_PHASE);
      wait_idle();

      $display("Covered %0d font writes, %0d renders (%0d pixels), %0d frame ticks",
               font_writes, renders, pixels_checked, ticks);
      $display("Cursor-lit lines %0d, blink wraps %0d, unused ops %0d, four cursor settings",
               cursor_lines, blink_wraps, unused_ops);
      if (errors == 0 && pixels_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/tmpg_pkg.sv
design/tmpg_if.sv
design/tmpg_ram.sv
design/tmpg_front.sv
design/tmpg_color.sv
design/tmpg_serializer.sv
design/text_mode_pixel_generator.sv
sim/text_mode_pixel_generator_test.sv
